// ===== hw/rtl/ancd_pkg.sv =====
//------------------------------------------------------------------------------
// ancd_pkg
// shared constants, register indexes and the job type for the analog
// normalizer with change detection
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ancd_pkg;

    localparam int SAMPLE_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF   = 16;

    localparam int SAMPLE_W   = 16;
    localparam int STAMP_W    = 32;
    localparam int RANGE_W    = 16;
    localparam int ID_W       = 8;
    localparam int S_TDATA_W  = 48;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_ENABLED        = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SEND_ON_CHANGE = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_INVERT         = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_RANGE_LOW      = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_RANGE_HIGH     = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_SENSOR_ID      = 3'd5;

    // 12-bit converter full scale
    localparam logic [RANGE_W-1:0] RANGE_HIGH_RST = 16'd4095;

    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [RANGE_W-1:0] num;
        logic [RANGE_W-1:0] den;
        logic               invert;
        logic [ID_W-1:0]    sensor;
        logic [STAMP_W-1:0] stamp;
    } job_t;

endpackage

`default_nettype wire

// ===== hw/rtl/ancd_front.sv =====
//------------------------------------------------------------------------------
// ancd_front
// configuration registers, item intake, clipping and divisor setup
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ancd_front #(
    parameter int SAMPLE_BITS = ancd_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_valid,
    output wire logic                              cfg_ready,
    input  wire logic [ancd_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [ancd_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  wire logic                              s_tvalid,
    output wire logic                              s_tready,
    input  wire logic [ancd_pkg::S_TDATA_W-1:0]    s_tdata,
    input  wire logic                              q_full,
    output      logic                              q_push,
    output      ancd_pkg::job_t                    q_job
);

    logic                            enabled_reg;
    logic                            soc_reg;
    logic                            invert_reg;
    logic [ancd_pkg::RANGE_W-1:0]    low_reg;
    logic [ancd_pkg::RANGE_W-1:0]    high_reg;
    logic [ancd_pkg::ID_W-1:0]       id_reg;

    logic [ancd_pkg::RANGE_W-1:0]    sample_word;
    logic [ancd_pkg::RANGE_W:0]      hi_eff;
    logic [ancd_pkg::RANGE_W:0]      clipped;
    logic [ancd_pkg::RANGE_W:0]      num_wide;
    logic [ancd_pkg::RANGE_W:0]      den_wide;

    assign cfg_ready = 1'b1;
    assign s_tready  = !q_full;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enabled_reg <= 1'b0;
            soc_reg     <= 1'b0;
            invert_reg  <= 1'b0;
            low_reg     <= '0;
            high_reg    <= ancd_pkg::RANGE_HIGH_RST;
            id_reg      <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                ancd_pkg::REG_ENABLED:        enabled_reg <= cfg_data[0];
                ancd_pkg::REG_SEND_ON_CHANGE: soc_reg     <= cfg_data[0];
                ancd_pkg::REG_INVERT:         invert_reg  <= cfg_data[0];
                ancd_pkg::REG_RANGE_LOW:      low_reg     <= cfg_data[ancd_pkg::RANGE_W-1:0];
                ancd_pkg::REG_RANGE_HIGH:     high_reg    <= cfg_data[ancd_pkg::RANGE_W-1:0];
                ancd_pkg::REG_SENSOR_ID:      id_reg      <= cfg_data[ancd_pkg::ID_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        sample_word = ancd_pkg::RANGE_W'(s_tdata[SAMPLE_BITS-1:0]);
        // high not above low acts as low + 1
        if (high_reg <= low_reg) begin
            hi_eff = {1'b0, low_reg} + 17'd1;
        end else begin
            hi_eff = {1'b0, high_reg};
        end
        if (sample_word < low_reg) begin
            clipped = {1'b0, low_reg};
        end else if ({1'b0, sample_word} > hi_eff) begin
            clipped = hi_eff;
        end else begin
            clipped = {1'b0, sample_word};
        end
        num_wide = clipped - {1'b0, low_reg};
        den_wide = hi_eff - {1'b0, low_reg};

        q_job.num    = num_wide[ancd_pkg::RANGE_W-1:0];
        q_job.den    = den_wide[ancd_pkg::RANGE_W-1:0];
        q_job.invert = invert_reg;
        q_job.sensor = id_reg;
        q_job.stamp  = s_tdata[ancd_pkg::SAMPLE_W +: ancd_pkg::STAMP_W];

        // disabled or sending off: item is consumed without a job
        q_push = s_tvalid && !q_full && enabled_reg && soc_reg;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/ancd_queue.sv =====
//------------------------------------------------------------------------------
// ancd_queue
// short job queue between intake and divider
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ancd_queue (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     push,
    input  ancd_pkg::job_t push_job,
    output wire logic     full,
    input  wire logic     pop,
    output wire logic     not_empty,
    output ancd_pkg::job_t head_job
);

    localparam int DEPTH = ancd_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    ancd_pkg::job_t     mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_job  = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/ancd_back.sv =====
//------------------------------------------------------------------------------
// ancd_back
// bit-serial divider, inversion, change compare and result register
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ancd_back #(
    parameter int FRAC_BITS = ancd_pkg::FRAC_BITS_DEF
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          q_not_empty,
    input  ancd_pkg::job_t     q_job,
    output      logic          q_pop,
    output wire logic          m_tvalid,
    input  wire logic          m_tready,
    output wire logic [((ancd_pkg::ID_W + FRAC_BITS + 1 + ancd_pkg::STAMP_W + 7) / 8) * 8 - 1:0]
                               m_tdata
);

    localparam int LVL_W     = FRAC_BITS + 1;
    localparam int M_FIELD_W = ancd_pkg::ID_W + LVL_W + ancd_pkg::STAMP_W;
    localparam int M_TDATA_W = ((M_FIELD_W + 7) / 8) * 8;
    localparam int CNT_W     = $clog2(FRAC_BITS);
    localparam logic [LVL_W-1:0] FULL   = LVL_W'(1) << FRAC_BITS;
    localparam logic [LVL_W-1:0] THRESH = LVL_W'((64'd1 << FRAC_BITS) / 64'd10000);
    localparam int RW = ancd_pkg::RANGE_W;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    state_t                         state_reg, state_next;
    logic [RW-1:0]                  rem_reg, rem_next;
    logic [RW-1:0]                  den_reg, den_next;
    logic [LVL_W-1:0]               quo_reg, quo_next;
    logic [CNT_W-1:0]               cnt_reg, cnt_next;
    logic                           inv_reg, inv_next;
    logic [ancd_pkg::ID_W-1:0]      id_reg, id_next;
    logic [ancd_pkg::STAMP_W-1:0]   stamp_reg, stamp_next;
    logic [LVL_W-1:0]               last_reg, last_next;
    logic                           out_valid_reg, out_valid_next;
    logic [M_TDATA_W-1:0]           out_data_reg, out_data_next;

    logic [RW:0]                    rem_dbl;
    logic [RW:0]                    rem_sub;
    logic                           q_bit;
    logic [LVL_W-1:0]               level;
    logic [LVL_W-1:0]               diff;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_comb begin
        state_next     = state_reg;
        rem_next       = rem_reg;
        den_next       = den_reg;
        quo_next       = quo_reg;
        cnt_next       = cnt_reg;
        inv_next       = inv_reg;
        id_next        = id_reg;
        stamp_next     = stamp_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        q_pop          = 1'b0;

        rem_dbl = {rem_reg, 1'b0};
        rem_sub = rem_dbl - {1'b0, den_reg};
        q_bit   = (rem_dbl >= {1'b0, den_reg});

        level = inv_reg ? (FULL - quo_reg) : quo_reg;
        diff  = (level > last_reg) ? (level - last_reg) : (last_reg - level);

        case (state_reg)
            ST_IDLE: begin
                if (q_not_empty) begin
                    q_pop      = 1'b1;
                    den_next   = q_job.den;
                    inv_next   = q_job.invert;
                    id_next    = q_job.sensor;
                    stamp_next = q_job.stamp;
                    cnt_next   = '0;
                    // numerator never exceeds divisor: integer bit is equality
                    if (q_job.num == q_job.den) begin
                        quo_next = LVL_W'(1);
                        rem_next = '0;
                    end else begin
                        quo_next = '0;
                        rem_next = q_job.num;
                    end
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                rem_next = q_bit ? rem_sub[RW-1:0] : rem_dbl[RW-1:0];
                quo_next = {quo_reg[LVL_W-2:0], q_bit};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(FRAC_BITS - 1)) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (diff <= THRESH) begin
                    state_next = ST_IDLE;
                end else if (!out_valid_reg || m_tready) begin
                    last_next      = level;
                    out_valid_next = 1'b1;
                    out_data_next  = M_TDATA_W'({stamp_reg, level, id_reg});
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            last_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg      <= rem_next;
        den_reg      <= den_next;
        quo_reg      <= quo_next;
        cnt_reg      <= cnt_next;
        inv_reg      <= inv_next;
        id_reg       <= id_next;
        stamp_reg    <= stamp_next;
        out_data_reg <= out_data_next;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/analog_normalize_change_detect_unit.sv =====
//------------------------------------------------------------------------------
// analog_normalize_change_detect_unit
// normalizes converter samples to a Q1.16 level and sends them on change
//------------------------------------------------------------------------------
// s_ channel: one sample item per handshake (sample, stamp in s_tdata).
// m_ channel: one result item (sensor number, level, stamp) when the level
//   moved by more than the change threshold since the last sent level.
// cfg channel: register writes by index, always ready; write only while idle.
// Path: an accepted item is queued, popped by the back end when idle, divided
//   one quotient bit per cycle, compared and loaded into the result register.
// Throughput is set by the bit-per-cycle divider in the back end; a two-entry
//   queue lets intake run ahead while it works.
// Items dropped while disabled or with sending off are consumed without a job.
// Reset: registers return to defaults (range 0..4095, all flags off), the
//   queue empties and the last sent level clears to zero.
// Receiver stall: the result holds in the output register, the divider may
//   finish the next item and waits, and s_tready drops once the queue fills.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module analog_normalize_change_detect_unit #(
    parameter int SAMPLE_BITS = ancd_pkg::SAMPLE_BITS_DEF,
    parameter int FRAC_BITS   = ancd_pkg::FRAC_BITS_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_valid,
    output wire logic                              cfg_ready,
    input  wire logic [ancd_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [ancd_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  wire logic                              s_tvalid,
    output wire logic                              s_tready,
    // sample [15:0], stamp [47:16]
    input  wire logic [ancd_pkg::S_TDATA_W-1:0]    s_tdata,
    output wire logic                              m_tvalid,
    input  wire logic                              m_tready,
    // sensor_number, level, stamp_out from bit 0 up, zero padded to bytes
    output wire logic [((ancd_pkg::ID_W + FRAC_BITS + 1 + ancd_pkg::STAMP_W + 7) / 8) * 8 - 1:0]
                                                   m_tdata
);

    logic           q_push;
    logic           q_pop;
    logic           q_full;
    logic           q_not_empty;
    ancd_pkg::job_t push_job;
    ancd_pkg::job_t head_job;

    ancd_front #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_job     (push_job)
    );

    ancd_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_job  (push_job),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head_job  (head_job)
    );

    ancd_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_not_empty (q_not_empty),
        .q_job       (head_job),
        .q_pop       (q_pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/ancd_checker.sv =====
//------------------------------------------------------------------------------
// ancd_checker
// port-level checks for the normalizer, bound to the top level
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ancd_checker #(
    parameter int FRAC_BITS = ancd_pkg::FRAC_BITS_DEF
) (
    input wire logic aclk,
    input wire logic aresetn,
    input wire logic s_tready,
    input wire logic m_tvalid,
    input wire logic m_tready,
    input wire logic [((ancd_pkg::ID_W + FRAC_BITS + 1 + ancd_pkg::STAMP_W + 7) / 8) * 8 - 1:0]
                     m_tdata
);

    localparam int LVL_LO = ancd_pkg::ID_W;
    localparam int LVL_W  = FRAC_BITS + 1;
    localparam logic [LVL_W-1:0] FULL = LVL_W'(1) << FRAC_BITS;

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_level_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[LVL_LO +: LVL_W] <= FULL)
        else $error("level above full scale");

    a_reset_out: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result pending after reset");

    a_reset_ready: assert property (@(posedge aclk)
        !aresetn |=> s_tready)
        else $error("intake not ready after reset");

endmodule

bind analog_normalize_change_detect_unit ancd_checker #(
    .FRAC_BITS (FRAC_BITS)
) u_ancd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
